// ----- rtl/multi_channel_phase_dimmer_unit_macros.svh -----
// Assertion helpers shared by the dimmer RTL.
// All checks run on i_clk and are off while i_rst_n is low.
`ifndef MULTI_CHANNEL_PHASE_DIMMER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_PHASE_DIMMER_UNIT_MACROS_SVH

// same-cycle implication
`define MCPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcpd assertion failed");

// next-cycle implication
`define MCPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mcpd assertion failed");

`endif

// ----- rtl/mcpd_pkg.sv -----
`default_nettype none

package mcpd_pkg;

    localparam int CHANNELS  = 8;
    localparam int OFF_DELAY = 128;
    localparam int ON_DELAY  = 0;
    localparam int LEVEL_TOP = 255;

    localparam int CFG_W   = 4;
    localparam int KIND_W  = 2;
    localparam int CH_W    = 3;
    localparam int LEVEL_W = 8;
    localparam int GATES_W = 8;
    localparam int DELAY_W = 8;

    // RAM address, and a count that can hold CHANNELS itself
    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);
    // common width for channel/count compares
    localparam int CMP_W = 6;
    localparam int SHOW  = (CHANNELS < GATES_W) ? CHANNELS : GATES_W;

    localparam int SPAN_MAG = (ON_DELAY > OFF_DELAY) ? (ON_DELAY - OFF_DELAY)
                                                     : (OFF_DELAY - ON_DELAY);

    typedef enum logic [KIND_W-1:0] {
        K_TICK = 2'd0,
        K_ZERO = 2'd1,
        K_SET  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               we;
        logic [AW-1:0]      waddr;
        logic [DELAY_W-1:0] wdata;
        logic [AW-1:0]      raddr;
    } t_ram_req;

    typedef struct packed {
        logic               valid;
        logic [GATES_W-1:0] gates;
        logic               bad;
    } t_result;

    function automatic logic [CNT_W-1:0] in_use(input logic [CFG_W-1:0] cfg);
        logic [CFG_W:0] a;
        a = {1'b0, cfg};
        if (a < (CFG_W+1)'(CHANNELS))
            return CNT_W'(a);
        else
            return CNT_W'(CHANNELS);
    endfunction

    // OFF + level*(ON-OFF)/255, truncated toward zero, clamped to [ON, OFF].
    // x/255 for x < 65535 is (x + (x>>8) + 1) >> 8.
    function automatic logic [DELAY_W-1:0] level_to_delay(input logic [LEVEL_W-1:0] level);
        logic [15:0]       p;
        logic [16:0]       s;
        logic [7:0]        q;
        logic signed [9:0] v;
        p = 16'(level) * 16'(SPAN_MAG);
        s = {1'b0, p} + 17'(p[15:8]) + 17'd1;
        q = s[15:8];
        if (ON_DELAY > OFF_DELAY)
            v = 10'(OFF_DELAY) + $signed({2'b00, q});
        else
            v = 10'(OFF_DELAY) - $signed({2'b00, q});
        if (v >= 10'(OFF_DELAY))
            return DELAY_W'(OFF_DELAY);
        else if (v <= 10'(ON_DELAY))
            return DELAY_W'(ON_DELAY);
        else
            return v[DELAY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mcpd_item_if.sv -----
`default_nettype none

interface mcpd_item_if;
    import mcpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output kind, output channel, output level, input ready);
    modport sink   (input valid, input kind, input channel, input level, output ready);
endinterface

`default_nettype wire

// ----- rtl/mcpd_result_if.sv -----
`default_nettype none

interface mcpd_result_if;
    import mcpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [GATES_W-1:0] gates;
    logic               bad_channel;

    modport source (output valid, output gates, output bad_channel, input ready);
    modport sink   (input valid, input gates, input bad_channel, output ready);
endinterface

`default_nettype wire

// ----- rtl/mcpd_ram.sv -----
`default_nettype none

module mcpd_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    parameter int ADDR_W = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/mcpd_ctrl.sv -----
`default_nettype none
`include "multi_channel_phase_dimmer_unit_macros.svh"

module mcpd_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mcpd_item_if.sink                        i_item,
    input  wire logic [mcpd_pkg::CNT_W-1:0]  i_n_use,
    output mcpd_pkg::t_ram_req               o_ram,
    input  wire logic [mcpd_pkg::DELAY_W-1:0] i_rdata,
    output mcpd_pkg::t_result                o_res,
    input  wire logic                        i_take
);
    import mcpd_pkg::*;

    t_state               r_state, n_state;
    logic [7:0]           r_counter;
    logic [CHANNELS-1:0]  r_wait;
    logic [CHANNELS-1:0]  r_gate;
    logic [CHANNELS-1:0]  r_dvalid;   // delay entry written since reset
    logic [CNT_W-1:0]     r_idx;
    logic [AW-1:0]        r_pidx;
    logic                 r_pend;
    logic                 r_bad;

    logic                 acc;
    logic                 set_ok;
    logic [AW-1:0]        set_addr;
    logic [DELAY_W-1:0]   cur_delay;
    logic                 fire;

    assign acc       = i_item.valid && i_item.ready;
    assign set_addr  = AW'(i_item.channel);
    assign set_ok    = CMP_W'(i_item.channel) < CMP_W'(i_n_use);
    assign cur_delay = r_dvalid[r_pidx] ? i_rdata : DELAY_W'(OFF_DELAY);
    assign fire      = r_pend && (CMP_W'(r_pidx) < CMP_W'(i_n_use)) && r_wait[r_pidx]
                       && (cur_delay <= r_counter) && (cur_delay != DELAY_W'(OFF_DELAY));

    always_comb begin
        o_ram.we    = acc && (t_kind'(i_item.kind) == K_SET) && set_ok;
        o_ram.waddr = set_addr;
        o_ram.wdata = level_to_delay(i_item.level);
        o_ram.raddr = r_idx[AW-1:0];
    end

    always_comb begin
        o_res.valid = (r_state == S_DONE);
        o_res.gates = GATES_W'(r_gate[SHOW-1:0]);
        o_res.bad   = r_bad;
    end

    always_comb begin
        i_item.ready = (r_state == S_IDLE);
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = (t_kind'(i_item.kind) == K_TICK) ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                if (r_pend && (CNT_W'(r_pidx) == CNT_W'(CHANNELS - 1))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_wait    <= '0;
            r_gate    <= '0;
            r_dvalid  <= '0;
            r_idx     <= '0;
            r_pidx    <= '0;
            r_pend    <= 1'b0;
            r_bad     <= 1'b0;
        end else begin
            if (r_state == S_IDLE && acc) begin
                r_bad  <= 1'b0;
                r_idx  <= '0;
                r_pend <= 1'b0;
                case (t_kind'(i_item.kind))
                    K_TICK: begin
                        if (r_counter != 8'hFF) begin
                            r_counter <= r_counter + 8'd1;
                        end
                    end
                    K_ZERO: begin
                        r_counter <= '0;
                        for (int i = 0; i < CHANNELS; i++) begin
                            if (CMP_W'(i) < CMP_W'(i_n_use)) begin
                                r_gate[i] <= 1'b0;
                                r_wait[i] <= 1'b1;
                            end
                        end
                    end
                    K_SET: begin
                        if (set_ok) begin
                            r_dvalid[set_addr] <= 1'b1;
                        end else begin
                            r_bad <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_WALK) begin
                // read issued here, data and compare follow in the next cycle
                if (r_idx < CNT_W'(CHANNELS)) begin
                    r_idx  <= r_idx + 1'b1;
                    r_pidx <= r_idx[AW-1:0];
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (fire) begin
                    r_gate[r_pidx] <= 1'b1;
                    r_wait[r_pidx] <= 1'b0;
                end
            end
        end
    end

    `MCPD_ASSERT_NXT(a_zero_clears_counter, acc && t_kind'(i_item.kind) == K_ZERO, r_counter == 8'd0)
    `MCPD_ASSERT_NXT(a_tick_counts, acc && t_kind'(i_item.kind) == K_TICK && r_counter != 8'hFF, r_counter == $past(r_counter) + 8'd1)
    `MCPD_ASSERT_IMP(a_gate_rises_in_walk, (r_gate & ~$past(r_gate)) != '0, $past(r_state) == S_WALK)
    `MCPD_ASSERT_IMP(a_counter_stable_in_walk, r_state == S_WALK && $past(r_state) == S_WALK, $stable(r_counter))

endmodule

`default_nettype wire

// ----- rtl/multi_channel_phase_dimmer_unit.sv -----
// Channel    Dir   Fields                          Accepted when
// i_item     in    kind[1:0] channel[2:0] level[7:0]  valid && ready
// o_result   out   gates[7:0] bad_channel          valid && ready
// i_cfg      in    active_outputs[3:0]             i_cfg_we high
//
// Tick item: handled by the walk over the delay RAM, one entry read per
// cycle, with the read data registered before the compare.
// Zero-cross, set-level and unused kinds skip the walk and go straight to the result.
// Reset is synchronous; delay entries read as OFF_DELAY until written,
// through per-entry valid flops, so there is no clearing pass.
// The output register frees the core while a result waits; the core stalls
// only when a second result is ready before the first is taken.
`default_nettype none
`include "multi_channel_phase_dimmer_unit_macros.svh"

module multi_channel_phase_dimmer_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mcpd_item_if.sink                        i_item,
    mcpd_result_if.source                    o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [mcpd_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import mcpd_pkg::*;

    logic [CFG_W-1:0]   r_active;
    logic               r_out_valid;
    logic [GATES_W-1:0] r_out_gates;
    logic               r_out_bad;

    t_ram_req           ram_req;
    t_result            res;
    logic [DELAY_W-1:0] rdata;
    logic               take;

    assign take = !r_out_valid || o_result.ready;

    mcpd_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (DELAY_W),
        .ADDR_W(AW)
    ) u_delay_ram (
        .i_clk  (i_clk),
        .i_we   (ram_req.we),
        .i_waddr(ram_req.waddr),
        .i_wdata(ram_req.wdata),
        .i_raddr(ram_req.raddr),
        .o_rdata(rdata)
    );

    mcpd_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_item),
        .i_n_use(in_use(r_active)),
        .o_ram  (ram_req),
        .i_rdata(rdata),
        .o_res  (res),
        .i_take (take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_W'(8);
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && take) begin
            r_out_gates <= res.gates;
            r_out_bad   <= res.bad;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.gates       = r_out_gates;
    assign o_result.bad_channel = r_out_bad;

    `MCPD_ASSERT_NXT(a_result_held, res.valid && !take, res.valid)
    `MCPD_ASSERT_NXT(a_result_loaded, res.valid && take, r_out_valid)
    `MCPD_ASSERT_NXT(a_out_hold, r_out_valid && !o_result.ready, r_out_valid && $stable(r_out_gates))

endmodule

`default_nettype wire
